[src/scanline_green_run_detector_macros.svh]
// assertion helpers for the scanline green run detector
`ifndef SCANLINE_GREEN_RUN_DETECTOR_MACROS_SVH
`define SCANLINE_GREEN_RUN_DETECTOR_MACROS_SVH

// same-cycle implication, quiet while reset is low
`define SGRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet while reset is low
`define SGRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) else $error(msg);

`endif

[src/sgrd_pkg.sv]
// ----------------------------------------------------------------------------
// sgrd_pkg
// shared constants, types, the pixel classifier and the x clamp of the green run detector
// ----------------------------------------------------------------------------
package sgrd_pkg;

    localparam int LINE_WIDTH = 4096;
    localparam int X_W        = 12;
    localparam int LEN_W      = 13;
    localparam int CNT_W      = 12;
    localparam int RGB_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [X_W-1:0]   X_MAX   = X_W'(LINE_WIDTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [LEN_W-1:0] MIN_WIDTH_RST       = 13'd3;
    localparam logic [X_W-1:0]   MERGE_GAP_RST       = 12'd4;
    localparam logic [LEN_W-1:0] MAX_WIDTH_RST       = 13'd4096;
    localparam logic [X_W-1:0]   PLAYER_RIGHT_PX_RST = 12'd0;

    localparam logic [7:0] G_MIN      = 8'd120;
    localparam logic [8:0] GR_MARGIN  = 9'd15;
    localparam logic [8:0] GB_MARGIN  = 9'd30;
    localparam logic [8:0] SPREAD_MIN = 9'd45;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_WIDTH       = 2'd0,
        CFG_MERGE_GAP       = 2'd1,
        CFG_MAX_WIDTH       = 2'd2,
        CFG_PLAYER_RIGHT_PX = 2'd3
    } t_cfg_idx;

    function automatic logic is_green(input logic [RGB_W-1:0] rgb);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] hi;
        logic [7:0] lo;
        r  = rgb[7:0];
        g  = rgb[15:8];
        b  = rgb[23:16];
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        return (g > G_MIN)
            && ({1'b0, g} > ({1'b0, r} + GR_MARGIN))
            && ({1'b0, g} > ({1'b0, b} + GB_MARGIN))
            && ({1'b0, hi} > ({1'b0, lo} + SPREAD_MIN));
    endfunction

    function automatic logic [X_W-1:0] clamp_x(input logic [X_W-1:0] x);
        return ({5'd0, x} >= 17'(LINE_WIDTH)) ? X_MAX : x;
    endfunction

endpackage

[src/scanline_green_run_detector.sv]
// ----------------------------------------------------------------------------
// scanline_green_run_detector
// finds the widest merged green segment on one scan line, one pixel a cycle
// ----------------------------------------------------------------------------
// throughput: one pixel beat per cycle, set by the run/segment
//   update on the pixel register; while a result is stalled at the output one
//   more line end waits in the line-end register, then the next last pixel
//   holds in the pixel register and the input stops until the output drains
// result path: the last pixel of a line passes the pixel register, the line-end
//   register and the output register; an output stall can hold it in each
// reset: synchronous active-low i_rst_n clears the line state and all valid
//   flags and loads the register defaults; the block is ready the next cycle
module scanline_green_run_detector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // pixel channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [sgrd_pkg::RGB_W-1:0]          i_pixel_rgb,
    input  logic [sgrd_pkg::X_W-1:0]            i_pixel_x,
    input  logic                                i_last_pixel,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_found,
    output logic [sgrd_pkg::X_W-1:0]            o_left_x,
    output logic [sgrd_pkg::X_W-1:0]            o_right_x,
    output logic [sgrd_pkg::X_W-1:0]            o_mid_x,
    output logic signed [sgrd_pkg::LEN_W-1:0]   o_edge_gap,
    output logic signed [sgrd_pkg::LEN_W-1:0]   o_center_distance,
    output logic [sgrd_pkg::CNT_W-1:0]          o_raw_runs,
    output logic [sgrd_pkg::CNT_W-1:0]          o_merged_runs,
    // register write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sgrd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sgrd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int XW = sgrd_pkg::X_W;
    localparam int LW = sgrd_pkg::LEN_W;
    localparam int CW = sgrd_pkg::CNT_W;

    // configuration registers
    logic [LW-1:0] r_min_width;
    logic [XW-1:0] r_merge_gap;
    logic [LW-1:0] r_max_width;
    logic [XW-1:0] r_player_right_px;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_width       <= sgrd_pkg::MIN_WIDTH_RST;
            r_merge_gap       <= sgrd_pkg::MERGE_GAP_RST;
            r_max_width       <= sgrd_pkg::MAX_WIDTH_RST;
            r_player_right_px <= sgrd_pkg::PLAYER_RIGHT_PX_RST;
        end else if (i_cfg_valid) begin
            unique case (sgrd_pkg::t_cfg_idx'(i_cfg_index))
                sgrd_pkg::CFG_MIN_WIDTH:       r_min_width       <= i_cfg_data;
                sgrd_pkg::CFG_MERGE_GAP:       r_merge_gap       <= i_cfg_data[XW-1:0];
                sgrd_pkg::CFG_MAX_WIDTH:       r_max_width       <= i_cfg_data;
                sgrd_pkg::CFG_PLAYER_RIGHT_PX: r_player_right_px <= i_cfg_data[XW-1:0];
                default: ;
            endcase
        end
    end

    // pipeline handshake
    logic r_in_valid;
    logic r_in_green;
    logic [XW-1:0] r_in_x;
    logic r_in_last;
    logic r_fin_valid;
    logic r_out_valid;
    logic out_free;
    logic fin_free;
    logic pix_go;

    assign out_free   = !r_out_valid || i_out_ready;
    assign fin_free   = !r_fin_valid || out_free;
    assign pix_go     = r_in_valid && (!r_in_last || fin_free);
    assign o_in_ready = !r_in_valid || pix_go;

    // classify on the way in so the update stage starts from a flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_green <= sgrd_pkg::is_green(i_pixel_rgb);
            r_in_x     <= sgrd_pkg::clamp_x(i_pixel_x);
            r_in_last  <= i_last_pixel;
        end
    end

    // line state
    logic          r_in_run;
    logic [XW-1:0] r_run_start;
    logic          r_seg_valid;
    logic [XW-1:0] r_seg_left;
    logic [XW-1:0] r_seg_right;
    logic          r_best_valid;
    logic [XW-1:0] r_best_left;
    logic [XW-1:0] r_best_right;
    logic [CW-1:0] r_run_count;
    logic [CW-1:0] r_seg_count;

    logic          close_en;
    logic [XW-1:0] close_start;
    logic [XW-1:0] close_end;
    logic [LW-1:0] run_len;
    logic          run_keep;
    logic          run_merge;
    logic          seg_wider;
    logic          n_in_run;
    logic [XW-1:0] n_run_start;
    logic          n_seg_valid;
    logic [XW-1:0] n_seg_left;
    logic [XW-1:0] n_seg_right;
    logic          n_best_valid;
    logic [XW-1:0] n_best_left;
    logic [XW-1:0] n_best_right;
    logic [CW-1:0] n_run_count;
    logic [CW-1:0] n_seg_count;

    // at most one run closes per pixel: a green last pixel closes at x,
    // a non-green pixel closes at x - 1
    assign close_en    = (r_in_run && (!r_in_green || r_in_last))
                      || (r_in_green && !r_in_run && r_in_last);
    assign close_start = r_in_run ? r_run_start : r_in_x;
    assign close_end   = r_in_green ? r_in_x : (r_in_x - XW'(1));
    assign run_len     = {1'b0, close_end} - {1'b0, close_start} + LW'(1);
    assign run_keep    = (close_end >= close_start) && (run_len >= r_min_width);
    // negative gaps merge as well
    assign run_merge   = r_seg_valid
                      && ({1'b0, close_start} <= ({1'b0, r_seg_right} + {1'b0, r_merge_gap}));
    assign seg_wider   = (r_seg_right - r_seg_left) > (r_best_right - r_best_left);

    always_comb begin
        n_in_run     = r_in_green && !r_in_last;
        n_run_start  = (r_in_green && !r_in_run) ? r_in_x : r_run_start;
        n_seg_valid  = r_seg_valid;
        n_seg_left   = r_seg_left;
        n_seg_right  = r_seg_right;
        n_best_valid = r_best_valid;
        n_best_left  = r_best_left;
        n_best_right = r_best_right;
        n_run_count  = r_run_count;
        n_seg_count  = r_seg_count;
        if (close_en) begin
            if (r_run_count != sgrd_pkg::CNT_MAX) begin
                n_run_count = r_run_count + CW'(1);
            end
            if (run_keep) begin
                if (run_merge) begin
                    if (close_end > r_seg_right) begin
                        n_seg_right = close_end;
                    end
                end else begin
                    // retire the open segment before starting a new one
                    if (r_seg_valid && (!r_best_valid || seg_wider)) begin
                        n_best_valid = 1'b1;
                        n_best_left  = r_seg_left;
                        n_best_right = r_seg_right;
                    end
                    n_seg_valid = 1'b1;
                    n_seg_left  = close_start;
                    n_seg_right = close_end;
                    if (r_seg_count != sgrd_pkg::CNT_MAX) begin
                        n_seg_count = r_seg_count + CW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run     <= 1'b0;
            r_run_start  <= '0;
            r_seg_valid  <= 1'b0;
            r_seg_left   <= '0;
            r_seg_right  <= '0;
            r_best_valid <= 1'b0;
            r_best_left  <= '0;
            r_best_right <= '0;
            r_run_count  <= '0;
            r_seg_count  <= '0;
        end else if (pix_go) begin
            if (r_in_last) begin
                r_in_run     <= 1'b0;
                r_seg_valid  <= 1'b0;
                r_best_valid <= 1'b0;
                r_run_count  <= '0;
                r_seg_count  <= '0;
            end else begin
                r_in_run     <= n_in_run;
                r_run_start  <= n_run_start;
                r_seg_valid  <= n_seg_valid;
                r_seg_left   <= n_seg_left;
                r_seg_right  <= n_seg_right;
                r_best_valid <= n_best_valid;
                r_best_left  <= n_best_left;
                r_best_right <= n_best_right;
                r_run_count  <= n_run_count;
                r_seg_count  <= n_seg_count;
            end
        end
    end

    // line-end stage: final segment against best, then the result fields
    logic          r_f_seg_valid;
    logic [XW-1:0] r_f_seg_left;
    logic [XW-1:0] r_f_seg_right;
    logic          r_f_best_valid;
    logic [XW-1:0] r_f_best_left;
    logic [XW-1:0] r_f_best_right;
    logic [CW-1:0] r_f_run_count;
    logic [CW-1:0] r_f_seg_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (pix_go && r_in_last) begin
            r_fin_valid <= 1'b1;
        end else if (out_free) begin
            r_fin_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_go && r_in_last) begin
            r_f_seg_valid  <= n_seg_valid;
            r_f_seg_left   <= n_seg_left;
            r_f_seg_right  <= n_seg_right;
            r_f_best_valid <= n_best_valid;
            r_f_best_left  <= n_best_left;
            r_f_best_right <= n_best_right;
            r_f_run_count  <= n_run_count;
            r_f_seg_count  <= n_seg_count;
        end
    end

    logic          f_take;
    logic          f_valid;
    logic [XW-1:0] f_left;
    logic [XW-1:0] f_right;
    logic [LW-1:0] f_len;
    logic          f_found;
    logic [LW-1:0] f_sum;
    logic [XW-1:0] f_center;

    assign f_take  = r_f_seg_valid && (!r_f_best_valid
                  || ((r_f_seg_right - r_f_seg_left) > (r_f_best_right - r_f_best_left)));
    assign f_valid = r_f_best_valid || f_take;
    assign f_left  = f_take ? r_f_seg_left  : r_f_best_left;
    assign f_right = f_take ? r_f_seg_right : r_f_best_right;
    assign f_len   = {1'b0, f_right} - {1'b0, f_left} + LW'(1);
    assign f_found = f_valid && (f_len <= r_max_width);
    assign f_sum   = {1'b0, f_left} + {1'b0, f_right};
    assign f_center = f_sum[LW-1:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_fin_valid) begin
            o_found       <= f_found;
            o_raw_runs    <= r_f_run_count;
            o_merged_runs <= r_f_seg_count;
            if (f_found) begin
                o_left_x          <= f_left;
                o_right_x         <= f_right;
                o_mid_x           <= f_center;
                o_edge_gap        <= signed'({1'b0, f_left} - {1'b0, r_player_right_px});
                o_center_distance <= signed'({1'b0, f_center} - {1'b0, r_player_right_px});
            end else begin
                o_left_x          <= '0;
                o_right_x         <= '0;
                o_mid_x           <= '0;
                o_edge_gap        <= '0;
                o_center_distance <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[src/sgrd_checker.sv]
// ----------------------------------------------------------------------------
// sgrd_checker
// port-level checks of the green run detector, bound to the top level
// ----------------------------------------------------------------------------
`include "scanline_green_run_detector_macros.svh"

module sgrd_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_in_ready,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic                                o_found,
    input logic [sgrd_pkg::X_W-1:0]            o_left_x,
    input logic [sgrd_pkg::X_W-1:0]            o_right_x,
    input logic [sgrd_pkg::X_W-1:0]            o_mid_x,
    input logic signed [sgrd_pkg::LEN_W-1:0]   o_edge_gap,
    input logic signed [sgrd_pkg::LEN_W-1:0]   o_center_distance,
    input logic [sgrd_pkg::CNT_W-1:0]          o_raw_runs,
    input logic [sgrd_pkg::CNT_W-1:0]          o_merged_runs
);

    // an empty output register never blocks pixels
    `SGRD_ASSERT_NOW(a_ready_when_drained, i_clk, i_rst_n, !o_out_valid, o_in_ready, "pixel input stalled with the output drained")

    // no detection means all edge fields read zero
    `SGRD_ASSERT_NOW(a_not_found_zero, i_clk, i_rst_n, o_out_valid && !o_found, (o_left_x == '0) && (o_right_x == '0) && (o_mid_x == '0) && (o_edge_gap == '0) && (o_center_distance == '0), "edge fields nonzero without a detection")

    // the center lies between the edges
    `SGRD_ASSERT_NOW(a_edges_ordered, i_clk, i_rst_n, o_out_valid && o_found, (o_left_x <= o_right_x) && (o_mid_x >= o_left_x) && (o_mid_x <= o_right_x), "segment edges or center out of order")

    // every merged segment comes from at least one run
    `SGRD_ASSERT_NOW(a_merged_le_raw, i_clk, i_rst_n, o_out_valid, o_merged_runs <= o_raw_runs, "more merged segments than raw runs")

    // a stalled result beat holds its found flag, edges and run counts
    `SGRD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_found) && $stable(o_left_x) && $stable(o_right_x) && $stable(o_raw_runs) && $stable(o_merged_runs), "stalled result beat changed")

endmodule

bind scanline_green_run_detector sgrd_checker u_sgrd_checker (.*);
